// File: rtl/core/tbrt_pkg.sv
package tbrt_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int MAX_RESULTS = 16;
	localparam int RES_W = $clog2(MAX_RESULTS + 1);

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(QUEUE_DEPTH - 1);
	localparam logic [RES_W-1:0] RES_LIMIT = RES_W'(MAX_RESULTS);

	localparam int MS_W = 10;
	localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;
	localparam logic [MS_W-1:0] MIN_TICK_RESET = 10'd50;

	localparam int TAG_W = 8;
	localparam int TOK_W = 32;
	localparam int DIV_STEP_W = 7;

	typedef enum logic [1:0] {
		REG_AVG_RATE = 2'd0,
		REG_BURST_LIMIT = 2'd1,
		REG_BURST_SECONDS = 2'd2,
		REG_MIN_TICK_MS = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_REQUEST = 1'b1
	} opcode_t;

	typedef enum logic {
		STAT_GRANTED = 1'b0,
		STAT_REJECTED = 1'b1
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TOK_W-1:0] tokens;
	} wait_entry_t;

	typedef struct packed {
		logic start;
		logic [63:0] dividend;
		logic [31:0] divisor;
		logic [DIV_STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

// File: rtl/core/tbrt_div.sv
module tbrt_div (
	input logic clk,
	input logic arst_n,
	input tbrt_pkg::div_req_t req,
	output tbrt_pkg::div_rsp_t rsp
);

	logic [63:0] dvd_q;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [tbrt_pkg::DIV_STEP_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic fits;

	assign shifted = {rem_q, dvd_q[63]};
	assign diff = shifted - {1'b0, dsr_q};
	assign fits = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == tbrt_pkg::DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			quo_q <= '0;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? diff[31:0] : shifted[31:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: rtl/core/tbrt_queue.sv
module tbrt_queue (
	input logic clk,
	input logic we,
	input logic [tbrt_pkg::HEAD_W-1:0] waddr,
	input tbrt_pkg::wait_entry_t wdata,
	input logic re,
	input logic [tbrt_pkg::HEAD_W-1:0] raddr,
	output tbrt_pkg::wait_entry_t rdata
);

	tbrt_pkg::wait_entry_t mem [tbrt_pkg::QUEUE_DEPTH];
	tbrt_pkg::wait_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/token_bucket_request_throttle.sv
// Token bucket request throttle. A word on the slave side is either a tick
// (tuser 0) that refills the bucket and releases waiting requests in order,
// or a request (tuser 1) that is granted at once when nothing waits and the
// bucket covers it or the rate is unlimited, and otherwise queues for its
// missing tokens; a request finding the queue full is rejected. Each result
// word carries the tag, a status in tuser and tlast on the final result of
// the input word. Inputs are taken one at a time. On the first tick after a
// rate change the tick works out the tick period, ticks per second and
// per-tick share on the shared divider; when the burst rate exceeds the
// average it runs the 64-step divider for the burst share; then it examines
// the waiters one by one. Output back-pressure stalls the block. Rate
// registers are taken on the plain write port; write them only while the
// block is idle, which the block itself does not enforce.
module token_bucket_request_throttle (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // request_id, token_count
	input logic s_axis_tuser, // opcode
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // granted_id
	output logic m_axis_tuser, // status
	output logic m_axis_tlast,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_wdata
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_REQ = 12'b000000000010,
		ST_TPS1 = 12'b000000000100,
		ST_TPS2 = 12'b000000001000,
		ST_QR = 12'b000000010000,
		ST_PUT = 12'b000000100000,
		ST_MUL = 12'b000001000000,
		ST_INC = 12'b000010000000,
		ST_AV = 12'b000100000000,
		ST_QRD = 12'b001000000000,
		ST_QEV = 12'b010000000000,
		ST_FIN = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [31:0] avg_q;
	logic [31:0] bl_q;
	logic [15:0] bs_q;
	logic [9:0] min_tick_q;
	logic [63:0] rem_tok_q;
	logic [63:0] avail_q;
	logic [63:0] cap_q;
	logic [31:0] max_q;
	logic [9:0] tps_q;
	logic [9:0] tidx_q;
	logic [9:0] acc_q;
	logic [31:0] fq_q;
	logic [9:0] fr_q;
	logic pend_q;
	logic [9:0] snap_min_q;
	logic [31:0] tokens_q;
	logic [63:0] inc_q;
	logic [tbrt_pkg::HEAD_W-1:0] head_q;
	logic [tbrt_pkg::CNT_W-1:0] count_q;
	logic [tbrt_pkg::RES_W-1:0] nres_q;
	logic held_v_q;
	logic [7:0] held_tag_q;
	logic [7:0] item_tag_q;
	logic [31:0] item_tok_q;
	logic out_valid_q;
	logic [7:0] out_tag_q;
	logic out_stat_q;
	logic out_last_q;

	tbrt_pkg::div_req_t div_req;
	tbrt_pkg::div_rsp_t div_rsp;
	tbrt_pkg::wait_entry_t q_rdata;
	tbrt_pkg::wait_entry_t q_wdata;
	logic q_we;
	logic q_re;
	logic [tbrt_pkg::HEAD_W-1:0] q_waddr;
	logic [tbrt_pkg::HEAD_W-1:0] tail;
	logic [tbrt_pkg::SUM_W-1:0] tail_sum;

	logic s_acc;
	logic out_free;
	logic out_push;
	logic release_all;
	logic covered;
	logic [63:0] q_need;
	logic req_take;
	logic [63:0] req_got;
	logic req_wait;
	logic req_emit;
	logic [9:0] tick0;
	logic [9:0] tick_lo;
	logic [9:0] tick_ms;
	logic tidx_wrap;
	logic [9:0] base_acc;
	logic [10:0] acc_sum;
	logic carry;
	logic [31:0] tokens_nx;
	logic [64:0] rem_add;
	logic [63:0] rem_filled;
	logic [63:0] lim;
	logic [64:0] av_add;
	logic [63:0] rem_after_q;
	logic [63:0] rem_after_req;
	logic [63:0] rem_after_part;

	logic [31:0] nx_avg;
	logic [31:0] nx_bl;
	logic [15:0] nx_bs;
	logic [31:0] eff;
	logic [15:0] bs_eff;
	logic [47:0] cap_prod;
	logic apply;

	assign s_acc = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_axis_tready;
	assign release_all = (avg_q == '0) || (max_q == '0);
	assign q_need = {32'd0, q_rdata.tokens};
	assign covered = release_all || (avail_q >= q_need);

	assign req_take = (count_q == '0) && (max_q != '0) && (avg_q != '0);
	assign req_got = !req_take ? 64'd0 :
		((avail_q >= {32'd0, item_tok_q}) ? {32'd0, item_tok_q} : avail_q);
	assign req_wait = (count_q != '0) || (req_take && (req_got < {32'd0, item_tok_q}));
	assign req_emit = !req_wait || (count_q >= tbrt_pkg::DEPTH_CNT);

	assign out_push = out_free && (((state_q == ST_REQ) && req_emit) ||
		((state_q == ST_QEV) && covered && held_v_q) ||
		((state_q == ST_FIN) && held_v_q));

	assign tail_sum = tbrt_pkg::SUM_W'(head_q) + tbrt_pkg::SUM_W'(count_q);
	assign tail = (tail_sum >= tbrt_pkg::DEPTH_SUM) ?
		tbrt_pkg::HEAD_W'(tail_sum - tbrt_pkg::DEPTH_SUM) : tbrt_pkg::HEAD_W'(tail_sum);

	assign tick0 = div_rsp.quotient[9:0];
	assign tick_lo = (tick0 < snap_min_q) ? snap_min_q : tick0;
	assign tick_ms = (tick_lo > tbrt_pkg::MS_PER_SECOND) ? tbrt_pkg::MS_PER_SECOND : tick_lo;

	assign tidx_wrap = tidx_q >= tps_q;
	assign base_acc = tidx_wrap ? 10'd0 : acc_q;
	assign acc_sum = {1'b0, base_acc} + {1'b0, fr_q};
	assign carry = acc_sum >= {1'b0, tps_q};
	assign tokens_nx = fq_q + {31'd0, carry};
	assign rem_add = {1'b0, rem_tok_q} + {33'd0, tokens_nx};
	assign rem_filled = (rem_add <= {1'b0, cap_q}) ? rem_add[63:0] : cap_q;
	assign lim = (rem_tok_q > {32'd0, max_q}) ? {32'd0, max_q} : rem_tok_q;
	assign av_add = {1'b0, avail_q} + {1'b0, inc_q};
	assign rem_after_q = (rem_tok_q >= q_need) ? rem_tok_q - q_need : 64'd0;
	assign rem_after_req = (rem_tok_q >= req_got) ? rem_tok_q - req_got : 64'd0;
	assign rem_after_part = (rem_tok_q >= avail_q) ? rem_tok_q - avail_q : 64'd0;

	always_comb begin
		nx_avg = (cfg_index == tbrt_pkg::REG_AVG_RATE) ? cfg_wdata : avg_q;
		nx_bl = (cfg_index == tbrt_pkg::REG_BURST_LIMIT) ? cfg_wdata : bl_q;
		nx_bs = (cfg_index == tbrt_pkg::REG_BURST_SECONDS) ? cfg_wdata[15:0] : bs_q;
		eff = ((nx_bl == '0) || (nx_bl < nx_avg)) ? nx_avg : nx_bl;
		bs_eff = (nx_bs == '0) ? 16'd1 : nx_bs;
		cap_prod = 48'(eff) * 48'(bs_eff);
		apply = cfg_we && (cfg_index != tbrt_pkg::REG_MIN_TICK_MS) && (nx_avg != '0);
	end

	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_req.start = s_acc && (s_axis_tuser == tbrt_pkg::OP_TICK) &&
					(avg_q != '0) && pend_q;
				div_req.dividend = {tbrt_pkg::MS_PER_SECOND, 54'd0};
				div_req.divisor = avg_q;
				div_req.steps = 7'd10;
			end
			ST_TPS1: begin
				div_req.start = div_rsp.done;
				div_req.dividend = {tbrt_pkg::MS_PER_SECOND, 54'd0};
				div_req.divisor = {22'd0, tick_ms};
				div_req.steps = 7'd10;
			end
			ST_TPS2: begin
				div_req.start = div_rsp.done;
				div_req.dividend = {avg_q, 32'd0};
				div_req.divisor = {22'd0, div_rsp.quotient[9:0]};
				div_req.steps = 7'd32;
			end
			ST_MUL: begin
				div_req.start = 1'b1;
				div_req.dividend = 64'(tokens_q) * 64'(max_q);
				div_req.divisor = avg_q;
				div_req.steps = 7'd64;
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	always_comb begin
		q_re = (state_q == ST_QRD) && (count_q != '0) && (nres_q != tbrt_pkg::RES_LIMIT);
		q_we = 1'b0;
		q_waddr = tail;
		q_wdata.tag = item_tag_q;
		q_wdata.tokens = item_tok_q - req_got[31:0];
		if (state_q == ST_REQ) begin
			q_we = !req_emit;
		end else if (state_q == ST_QEV) begin
			q_we = !covered;
			q_waddr = head_q;
			q_wdata.tag = q_rdata.tag;
			q_wdata.tokens = q_rdata.tokens - avail_q[31:0];
		end
	end

	tbrt_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	tbrt_queue u_queue (
		.clk(clk),
		.we(q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.re(q_re),
		.raddr(head_q),
		.rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			avg_q <= '0;
			bl_q <= '0;
			bs_q <= 16'd1;
			min_tick_q <= tbrt_pkg::MIN_TICK_RESET;
			rem_tok_q <= '0;
			avail_q <= '0;
			cap_q <= '0;
			max_q <= '0;
			tps_q <= 10'd1;
			tidx_q <= '0;
			acc_q <= '0;
			pend_q <= 1'b0;
			head_q <= '0;
			count_q <= '0;
			nres_q <= '0;
			held_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					nres_q <= '0;
					if (s_acc) begin
						if (s_axis_tuser == tbrt_pkg::OP_REQUEST) begin
							state_q <= ST_REQ;
						end else if (avg_q == '0) begin
							state_q <= ST_QRD;
						end else if (pend_q) begin
							state_q <= ST_TPS1;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_REQ: begin
					if (!req_emit || out_free) begin
						avail_q <= avail_q - req_got;
						rem_tok_q <= rem_after_req;
						state_q <= ST_IDLE;
						if (!req_emit) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_TPS1: begin
					if (div_rsp.done) begin
						state_q <= ST_TPS2;
					end
				end
				ST_TPS2: begin
					if (div_rsp.done) begin
						tps_q <= div_rsp.quotient[9:0];
						state_q <= ST_QR;
					end
				end
				ST_QR: begin
					if (div_rsp.done) begin
						fq_q <= div_rsp.quotient[31:0];
						fr_q <= div_rsp.remainder[9:0];
						pend_q <= 1'b0;
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					tidx_q <= tidx_wrap ? 10'd1 : tidx_q + 10'd1;
					acc_q <= carry ? 10'(acc_sum - {1'b0, tps_q}) : acc_sum[9:0];
					tokens_q <= tokens_nx;
					inc_q <= {32'd0, tokens_nx};
					if ((max_q == '0) || (tokens_nx == '0)) begin
						state_q <= ST_QRD;
					end else begin
						rem_tok_q <= rem_filled;
						state_q <= (max_q > avg_q) ? ST_MUL : ST_AV;
					end
				end
				ST_MUL: begin
					state_q <= ST_INC;
				end
				ST_INC: begin
					if (div_rsp.done) begin
						inc_q <= div_rsp.quotient;
						state_q <= ST_AV;
					end
				end
				ST_AV: begin
					avail_q <= (av_add <= {1'b0, lim}) ? av_add[63:0] : lim;
					state_q <= ST_QRD;
				end
				ST_QRD: begin
					state_q <= q_re ? ST_QEV : ST_FIN;
				end
				ST_QEV: begin
					if (!covered) begin
						avail_q <= '0;
						rem_tok_q <= rem_after_part;
						state_q <= ST_FIN;
					end else if (!held_v_q || out_free) begin
						held_v_q <= 1'b1;
						if (!release_all) begin
							avail_q <= avail_q - q_need;
							rem_tok_q <= rem_after_q;
						end
						head_q <= (head_q == tbrt_pkg::HEAD_LAST) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
						nres_q <= nres_q + 1'b1;
						state_q <= ST_QRD;
					end
				end
				ST_FIN: begin
					if (!held_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						held_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					tbrt_pkg::REG_AVG_RATE: avg_q <= cfg_wdata;
					tbrt_pkg::REG_BURST_LIMIT: bl_q <= cfg_wdata;
					tbrt_pkg::REG_BURST_SECONDS: bs_q <= cfg_wdata[15:0];
					tbrt_pkg::REG_MIN_TICK_MS: begin
						if (cfg_wdata[9:0] != '0) begin
							min_tick_q <= cfg_wdata[9:0];
						end
					end
					default: begin
					end
				endcase
			end
			if (apply) begin
				pend_q <= 1'b1;
				tidx_q <= '0;
				acc_q <= '0;
				if (cap_q != 64'(cap_prod)) begin
					cap_q <= 64'(cap_prod);
					rem_tok_q <= 64'(cap_prod);
				end
				if (avail_q > {32'd0, eff}) begin
					avail_q <= {32'd0, eff};
				end
				max_q <= eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_tag_q <= s_axis_tdata[7:0];
			item_tok_q <= s_axis_tdata[39:8];
		end
		if (apply) begin
			snap_min_q <= min_tick_q;
		end
		if ((state_q == ST_QEV) && covered && (!held_v_q || out_free)) begin
			held_tag_q <= q_rdata.tag;
			if (held_v_q) begin
				out_tag_q <= held_tag_q;
				out_stat_q <= tbrt_pkg::STAT_GRANTED;
				out_last_q <= 1'b0;
			end
		end else if ((state_q == ST_FIN) && held_v_q && out_free) begin
			out_tag_q <= held_tag_q;
			out_stat_q <= tbrt_pkg::STAT_GRANTED;
			out_last_q <= 1'b1;
		end else if ((state_q == ST_REQ) && req_emit && out_free) begin
			out_tag_q <= item_tag_q;
			out_stat_q <= req_wait ? tbrt_pkg::STAT_REJECTED : tbrt_pkg::STAT_GRANTED;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_tag_q;
	assign m_axis_tuser = out_stat_q;
	assign m_axis_tlast = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tbrt_pkg::DEPTH_CNT)
		else $error("queue count above depth");

	a_avail_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= {32'd0, max_q})
		else $error("available tokens above burst maximum");

	a_rem_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rem_tok_q <= cap_q)
		else $error("remaining tokens above capacity");

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !held_v_q)
		else $error("held result left behind at idle");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= tbrt_pkg::RES_LIMIT)
		else $error("too many results for one tick");

endmodule
